FILE: sv/rdot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rdot_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 30;
	localparam int MAG_W      = SUM_W - 1;
	localparam int CNT_W      = 14;
	localparam int AVG_W      = 36;
	localparam int CORR_W     = 7;
	localparam int THR_W      = 26;
	localparam int DAMP_SHIFT = 10;
	localparam int PROD_W     = AVG_W + DAMP_SHIFT;
	localparam int DIV_STEPS  = MAG_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]         MAX_BLOCK_SAMPLES = CNT_W'(8192);
	localparam logic signed [CORR_W-1:0] MAX_CORRECTION    = CORR_W'(63);

	// configuration register indexes
	localparam logic REG_MAX_OFFSET   = 1'b0;
	localparam logic REG_AUTO_CORRECT = 1'b1;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_i;
		logic signed [SUM_W-1:0] sum_q;
		logic [CNT_W-1:0]        cnt;
	} blk_t;

	typedef struct packed {
		logic [THR_W-1:0] max_offset;
		logic             auto_en;
	} cfg_t;

endpackage
`default_nettype wire

FILE: sv/rdot_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rdot_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [31:0]         s_axis_tdata,
	input  wire logic                s_axis_tlast,
	input  wire logic                q_full,
	output logic                     push,
	output rdot_pkg::blk_t           push_blk
);
	import rdot_pkg::*;

	logic signed [SUM_W-1:0] sum_i_q, sum_q_q, sum_i_n, sum_q_n;
	logic [CNT_W-1:0]        cnt_q, cnt_n;
	logic                    add_en, acc;

	always_comb begin
		add_en  = cnt_q < MAX_BLOCK_SAMPLES;
		sum_i_n = sum_i_q;
		sum_q_n = sum_q_q;
		cnt_n   = cnt_q;
		if (add_en) begin
			sum_i_n = sum_i_q + {{(SUM_W-SAMPLE_W){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
			sum_q_n = sum_q_q + {{(SUM_W-SAMPLE_W){s_axis_tdata[31]}}, s_axis_tdata[31:16]};
			cnt_n   = cnt_q + CNT_W'(1);
		end
	end

	assign s_axis_tready = !q_full;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign push          = acc && s_axis_tlast;
	assign push_blk      = '{sum_i: sum_i_n, sum_q: sum_q_n, cnt: cnt_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_i_q <= '0;
			sum_q_q <= '0;
			cnt_q   <= '0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				sum_i_q <= '0;
				sum_q_q <= '0;
				cnt_q   <= '0;
			end else begin
				sum_i_q <= sum_i_n;
				sum_q_q <= sum_q_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/rdot_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rdot_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rdot_pkg::blk_t  push_blk,
	output logic                 full,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output rdot_pkg::blk_t       rd_blk
);
	import rdot_pkg::*;

	blk_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign full     = fill_q == 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_blk   = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/rdot_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rdot_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rdot_pkg::cfg_t  cfg,
	input  wire logic            rd_valid,
	output logic                 rd_ready,
	input  wire rdot_pkg::blk_t  rd_blk,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [47:0]          m_axis_tdata
);
	import rdot_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;

	function automatic logic [CNT_W+MAG_W-1:0] div_step(
		input logic [CNT_W-1:0] rem,
		input logic [MAG_W-1:0] dq,
		input logic [CNT_W-1:0] d
	);
		logic [CNT_W:0] trial;
		trial = {rem, dq[MAG_W-1]};
		if (trial >= {1'b0, d})
			div_step = {CNT_W'(trial - {1'b0, d}), dq[MAG_W-2:0], 1'b1};
		else
			div_step = {trial[CNT_W-1:0], dq[MAG_W-2:0], 1'b0};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] signed_mean(
		input logic [MAG_W-1:0] q,
		input logic             neg
	);
		logic [SAMPLE_W:0] m;
		m = q[SAMPLE_W:0];
		signed_mean = neg ? SAMPLE_W'(-m) : m[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [AVG_W-1:0] damp(
		input logic signed [PROD_W-1:0]   p,
		input logic signed [SAMPLE_W-1:0] mean
	);
		logic [PROD_W-1:0] t;
		// truncate toward zero on the division by the damping factor
		t = p + (p[PROD_W-1] ? PROD_W'((1 << DAMP_SHIFT) - 1) : PROD_W'(0));
		damp = t[PROD_W-1:DAMP_SHIFT] + {{(AVG_W-SAMPLE_W){mean[SAMPLE_W-1]}}, mean};
	endfunction

	function automatic logic signed [CORR_W-1:0] step_corr(
		input logic signed [AVG_W-1:0]  avg,
		input logic signed [CORR_W-1:0] corr,
		input logic [THR_W-1:0]         thr
	);
		logic signed [AVG_W:0] a, t;
		a = {avg[AVG_W-1], avg};
		t = {{(AVG_W+1-THR_W){1'b0}}, thr};
		if (a > t && corr < MAX_CORRECTION)
			step_corr = corr + CORR_W'(1);
		else if (a < -t && corr > -MAX_CORRECTION)
			step_corr = corr - CORR_W'(1);
		else
			step_corr = corr;
	endfunction

	logic [2:0]                state_q;
	logic [STEP_W-1:0]         step_q;
	logic [MAG_W-1:0]          dq_i_q, dq_q_q;
	logic [CNT_W-1:0]          rem_i_q, rem_q_q, div_q;
	logic                      neg_i_q, neg_q_q;
	logic signed [SAMPLE_W-1:0] mean_i_q, mean_q_q;
	logic signed [PROD_W-1:0]  p_i_q, p_q_q;
	logic signed [AVG_W-1:0]   avg_i_q, avg_q_q;
	logic signed [CORR_W-1:0]  com_i_q, com_q_q, ci, cq;
	logic [SUM_W-1:0]          abs_i, abs_q;
	logic                      out_free, commit;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign rd_ready = state_q == ST_IDLE;
	assign abs_i    = rd_blk.sum_i[SUM_W-1] ? SUM_W'(-rd_blk.sum_i) : rd_blk.sum_i;
	assign abs_q    = rd_blk.sum_q[SUM_W-1] ? SUM_W'(-rd_blk.sum_q) : rd_blk.sum_q;
	assign ci       = step_corr(avg_i_q, com_i_q, cfg.max_offset);
	assign cq       = step_corr(avg_q_q, com_q_q, cfg.max_offset);
	assign commit   = cfg.auto_en && (ci != com_i_q || cq != com_q_q);

	// division and damping datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dq_i_q  <= abs_i[MAG_W-1:0];
				dq_q_q  <= abs_q[MAG_W-1:0];
				rem_i_q <= '0;
				rem_q_q <= '0;
				div_q   <= rd_blk.cnt;
				neg_i_q <= rd_blk.sum_i[SUM_W-1];
				neg_q_q <= rd_blk.sum_q[SUM_W-1];
			end
			ST_DIV: begin
				{rem_i_q, dq_i_q} <= div_step(rem_i_q, dq_i_q, div_q);
				{rem_q_q, dq_q_q} <= div_step(rem_q_q, dq_q_q, div_q);
			end
			ST_MUL: begin
				mean_i_q <= signed_mean(dq_i_q, neg_i_q);
				mean_q_q <= signed_mean(dq_q_q, neg_q_q);
				p_i_q <= (PROD_W'(avg_i_q) <<< DAMP_SHIFT) - PROD_W'(avg_i_q);
				p_q_q <= (PROD_W'(avg_q_q) <<< DAMP_SHIFT) - PROD_W'(avg_q_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			avg_i_q       <= '0;
			avg_q_q       <= '0;
			com_i_q       <= '0;
			com_q_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_STEP && out_free)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (rd_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					avg_i_q <= damp(p_i_q, mean_i_q);
					avg_q_q <= damp(p_q_q, mean_q_q);
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (out_free) begin
						if (ci != com_i_q) avg_i_q <= '0;
						if (cq != com_q_q) avg_q_q <= '0;
						if (commit) begin
							com_i_q <= ci;
							com_q_q <= cq;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STEP && out_free)
			m_axis_tdata <= {1'b0, commit,
				commit ? cq : com_q_q, commit ? ci : com_i_q, mean_q_q, mean_i_q};
	end

endmodule
`default_nettype wire

FILE: sv/rx_dc_offset_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Receive DC offset tracker. I/Q samples enter on the slave stream, one per cycle while
// s_axis_tready is high; tlast closes an averaging block (samples past the first 8192 of a
// block are dropped but tlast still closes it). Each closed block yields one request on the
// master stream with the truncated block means, the committed I/Q corrections (within +-63)
// and a changed flag. The front sums samples at full rate and hands finished blocks to a
// two-entry queue; the back works one block at a time through its one-bit-per-cycle
// 29-step divider and the damping and step stages. Input stalls while the queue is full,
// as when blocks close faster than the back retires them or the master stream holds off.
// Config registers: index 0 max_offset (26 bit, reset 10240), index 1 auto_correct_enable
// (reset 1); write them only while the block is idle.
module rx_dc_offset_tracker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // sample_i[15:0], sample_q[31:16]
	input  wire logic        s_axis_tlast,  // last_in_block
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// block_mean_i[15:0], block_mean_q[31:16], offset_i[38:32], offset_q[45:39],
	// offset_changed[46], zero pad[47]
	output logic [47:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [25:0] cfg_wdata
);
	import rdot_pkg::*;

	cfg_t cfg_q;
	blk_t push_blk, rd_blk;
	logic push, q_full, rd_valid, rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_offset <= THR_W'(10240);
			cfg_q.auto_en    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_OFFSET:   cfg_q.max_offset <= cfg_wdata;
				REG_AUTO_CORRECT: cfg_q.auto_en    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	rdot_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_blk      (push_blk)
	);

	rdot_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_blk (push_blk),
		.full     (q_full),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_blk   (rd_blk)
	);

	rdot_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rd_valid      (rd_valid),
		.rd_ready      (rd_ready),
		.rd_blk        (rd_blk),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// no change is reported while automatic correction is off
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[46] && !cfg_q.auto_en))
		else $error("offset change reported with auto correction off");

	// committed corrections never reach -64
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'h40 && m_axis_tdata[45:39] != 7'h40))
		else $error("correction out of range");

	// a block entering a full queue would be lost
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("block pushed into full queue");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import rdot_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] i;
		logic [SAMPLE_W-1:0] q;
		logic                last;
	} iq_sample_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] mean_i;
		logic signed [SAMPLE_W-1:0] mean_q;
		logic signed [CORR_W-1:0]   off_i;
		logic signed [CORR_W-1:0]   off_q;
		logic                       changed;
	} dc_report_t;

	// sign of the generated sample values; LEVEL_MIXED picks one of the others per block
	typedef enum int {LEVEL_ANY, LEVEL_POS, LEVEL_NEG, LEVEL_MIXED} level_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;  // sample_i[15:0], sample_q[31:16]
	logic              s_axis_tlast = 1'b0; // last_in_block
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// block_mean_i[15:0], block_mean_q[31:16], offset_i[38:32], offset_q[45:39],
	// offset_changed[46], zero pad[47]
	logic [47:0]       m_axis_tdata;
	logic              cfg_we = 1'b0;
	logic              cfg_addr = REG_MAX_OFFSET;
	logic [THR_W-1:0]  cfg_wdata = '0;

	rx_dc_offset_tracker_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	// tracker state mirrored from the block
	logic [THR_W-1:0]         thr = THR_W'(10240);
	logic                     auto_en = 1'b1;
	logic signed [SUM_W-1:0]  acc_i = '0;
	logic signed [SUM_W-1:0]  acc_q = '0;
	logic [CNT_W-1:0]         blk_cnt = '0;
	logic signed [AVG_W-1:0]  avg_i = '0;
	logic signed [AVG_W-1:0]  avg_q = '0;
	logic signed [CORR_W-1:0] corr_i = '0;
	logic signed [CORR_W-1:0] corr_q = '0;

	iq_sample_t  sample_backlog[$];
	dc_report_t  pending_reports[$];
	iq_sample_t  tx_item;
	dc_report_t  want;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	bit          quiet = 1'b0;
	bit          in_acc = 1'b0;
	int          err_cnt = 0;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CORR_W-1:0] step_corr(inout logic signed [AVG_W-1:0] avg,
		input logic signed [CORR_W-1:0] corr);
		if (longint'(avg) > longint'(thr) && corr < MAX_CORRECTION) begin
			avg = '0;
			return corr + CORR_W'(1);
		end
		if (longint'(avg) < -longint'(thr) && corr > -MAX_CORRECTION) begin
			avg = '0;
			return corr - CORR_W'(1);
		end
		return corr;
	endfunction

	// one accepted sample; a block end queues the report it must produce
	function automatic void track_sample(logic signed [SAMPLE_W-1:0] si,
		logic signed [SAMPLE_W-1:0] sq, logic last);
		longint mi, mq;
		logic signed [CORR_W-1:0] ni, nq;
		dc_report_t rep;
		if (blk_cnt < MAX_BLOCK_SAMPLES) begin
			acc_i += si;
			acc_q += sq;
			blk_cnt++;
		end
		if (!last)
			return;
		mi = longint'(acc_i) / longint'(blk_cnt);
		mq = longint'(acc_q) / longint'(blk_cnt);
		acc_i = '0;
		acc_q = '0;
		blk_cnt = '0;
		avg_i = AVG_W'(longint'(avg_i) * 1023 / 1024 + mi);
		avg_q = AVG_W'(longint'(avg_q) * 1023 / 1024 + mq);
		ni = step_corr(avg_i, corr_i);
		nq = step_corr(avg_q, corr_q);
		rep.changed = 1'b0;
		if (auto_en && (ni != corr_i || nq != corr_q)) begin
			corr_i = ni;
			corr_q = nq;
			rep.changed = 1'b1;
		end
		rep.mean_i = SAMPLE_W'(mi);
		rep.mean_q = SAMPLE_W'(mq);
		rep.off_i = corr_i;
		rep.off_q = corr_q;
		pending_reports.push_back(rep);
	endfunction

	function automatic bit same(string name, logic signed [SAMPLE_W-1:0] exp_v,
		logic signed [SAMPLE_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// sample side
	always @(negedge clk) begin
		if (!(s_axis_tvalid && !in_acc)) begin
			if (tx_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap--;
			end else if (sample_backlog.size() != 0) begin
				tx_item = sample_backlog.pop_front();
				s_axis_tdata <= {tx_item.q, tx_item.i};
				s_axis_tlast <= tx_item.last;
				s_axis_tvalid <= 1'b1;
				tx_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// report side, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 400;
			m_axis_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			m_axis_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_axis_tready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		in_acc <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			track_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report %h", m_axis_tdata);
				err_cnt++;
			end else begin
				want = pending_reports.pop_front();
				if (!same("block_mean_i", want.mean_i, $signed(m_axis_tdata[15:0])))
					err_cnt++;
				if (!same("block_mean_q", want.mean_q, $signed(m_axis_tdata[31:16])))
					err_cnt++;
				if (!same("offset_i", want.off_i, $signed(m_axis_tdata[38:32])))
					err_cnt++;
				if (!same("offset_q", want.off_q, $signed(m_axis_tdata[45:39])))
					err_cnt++;
				if (!same("offset_changed", want.changed, m_axis_tdata[46]))
					err_cnt++;
			end
		end
	end

	task automatic push_sample(int si, int sq, bit last);
		iq_sample_t s;
		s.i = SAMPLE_W'(si);
		s.q = SAMPLE_W'(sq);
		s.last = last;
		sample_backlog.push_back(s);
	endtask

	function automatic int rand_sample(level_t lv);
		if ($urandom_range(0, 7) == 0) begin
			if (lv == LEVEL_POS)
				return 32767;
			if (lv == LEVEL_NEG)
				return -32768;
			return $urandom_range(0, 1) ? 32767 : -32768;
		end
		case (lv)
			LEVEL_POS: return $urandom_range(0, 32767);
			LEVEL_NEG: return -int'($urandom_range(1, 32768));
			default:   return int'($signed(SAMPLE_W'($urandom)));
		endcase
	endfunction

	function automatic level_t pick_level(level_t lv);
		if (lv != LEVEL_MIXED)
			return lv;
		case ($urandom_range(0, 2))
			0:       return LEVEL_POS;
			1:       return LEVEL_NEG;
			default: return LEVEL_ANY;
		endcase
	endfunction

	// whole blocks, mostly short, until n samples are queued
	task automatic add_blocks(int unsigned n, int unsigned max_len, level_t lv_i, level_t lv_q);
		int unsigned len;
		level_t bi, bq;
		while (n > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
				6, 7, 8:          len = $urandom_range(5, 40);
				default:          len = $urandom_range(41, 150);
			endcase
			if (len > max_len)
				len = max_len;
			if (len > n)
				len = n;
			bi = pick_level(lv_i);
			bq = pick_level(lv_q);
			for (int unsigned k = 1; k <= len; k++)
				push_sample(rand_sample(bi), rand_sample(bq), k == len);
			n -= len;
		end
	endtask

	task automatic write_reg(logic addr, logic [THR_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		if (addr == REG_MAX_OFFSET)
			thr = data;
		else
			auto_en = data[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// all samples taken and every report back, then let the back end settle
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (sample_backlog.size() != 0 || (s_axis_tvalid && !in_acc) ||
			pending_reports.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// extremes, truncation toward zero, multi-sample blocks
		push_sample(32767, -32768, 1'b1);
		push_sample(-32768, 32767, 1'b1);
		push_sample(0, 0, 1'b1);
		push_sample(-5, 7, 1'b0);
		push_sample(-5, 7, 1'b0);
		push_sample(-6, 8, 1'b1);
		push_sample(1, -1, 1'b0);
		push_sample(0, 0, 1'b1);
		repeat (3) push_sample(32767, -32768, 1'b0);
		push_sample(32766, -32767, 1'b1);
		for (int k = 0; k < 7; k++)
			push_sample(k[0] ? -32768 : 32767, k[0] ? 32767 : -32768, 1'b0);
		push_sample(-1, 1, 1'b1);
		push_sample('h5555, 'haaaa, 1'b0);
		push_sample('haaaa, 'h5555, 1'b1);
		wait_idle();

		// zero threshold drives the corrections into both limits; report side held off once
		write_reg(REG_MAX_OFFSET, '0);
		write_reg(REG_AUTO_CORRECT, 1'b1);
		hold_req++;
		add_blocks(90, 1, LEVEL_POS, LEVEL_NEG);
		add_blocks(110, 1, LEVEL_NEG, LEVEL_POS);
		wait_idle();

		// stepping with nothing committed
		write_reg(REG_AUTO_CORRECT, 1'b0);
		write_reg(REG_MAX_OFFSET, THR_W'($urandom_range(0, 20000)));
		add_blocks(150, 150, LEVEL_MIXED, LEVEL_MIXED);
		wait_idle();

		// threshold out of reach, no idling
		quiet = 1'b1;
		write_reg(REG_MAX_OFFSET, {THR_W{1'b1}});
		write_reg(REG_AUTO_CORRECT, 1'b1);
		add_blocks(100, 150, LEVEL_MIXED, LEVEL_MIXED);
		wait_idle();

		// overlong block: samples past the limit are dropped, tlast still closes it
		write_reg(REG_MAX_OFFSET, THR_W'($urandom_range(1000, 30000)));
		for (int k = 1; k <= 8195; k++)
			push_sample(rand_sample(LEVEL_ANY), rand_sample(LEVEL_ANY), k == 8195);
		wait_idle();
		quiet = 1'b0;
		add_blocks(250, 150, LEVEL_MIXED, LEVEL_MIXED);
		wait_idle();

		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
